>>> sv/ps2mt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
`default_nettype none

package ps2mt_pkg;

  // Default sizing of internal position and accumulator storage
  localparam int COORD_BITS_DEF = 13;
  localparam int REL_BITS_DEF   = 16;

  // Fixed field widths on the ports
  localparam int POS_W  = 13;
  localparam int RELO_W = 16;
  localparam int SIZE_W = 14;

  // Action codes
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_SET  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Flags byte masks
  localparam logic [7:0] FLAG_BUTTONS  = 8'h07;
  localparam logic [7:0] FLAG_OVERFLOW = 8'hC0;
  localparam logic [7:0] FLAG_XSIGN    = 8'h10;
  localparam logic [7:0] FLAG_YSIGN    = 8'h20;
  localparam logic [7:0] FLAG_SYNC     = 8'h08;

  // Reset values
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 14'd1024;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 14'd768;
  localparam int RST_X = 512;
  localparam int RST_Y = 384;

  typedef struct packed {
    logic [1:0]         action;
    logic               from_aux;
    logic [7:0]         data_byte;
    logic signed [15:0] set_x;
    logic signed [15:0] set_y;
    logic [2:0]         set_buttons;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic [2:0]               button_bits;
    logic signed [RELO_W-1:0] rel_x;
    logic signed [RELO_W-1:0] rel_y;
    logic                     packet_done;
    logic                     motion_dropped;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/ps2mt_ifs.sv
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none

interface ps2mt_in_if
  import ps2mt_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ps2mt_out_if
  import ps2mt_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/ps2_mouse_packet_tracker_top.sv
// PS/2 mouse packet tracker: framing, button latch, relative and absolute motion.
// Input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while not stalled; tracker state updates as
// the result loads. Stalls on the result side back up through the input register only.
// Reset (synchronous, rst_n low): framing idle, position 512/384, buttons and motion
// cleared, screen size 1024 x 768.
`default_nettype none

module ps2_mouse_packet_tracker_top
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int REL_BITS   = REL_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data,
  ps2mt_in_if.sink               in_if,
  ps2mt_out_if.source            out_if
);

  // Position storage must also hold the reset center
  localparam int PW  = (COORD_BITS > 10) ? COORD_BITS : 10;
  localparam int CLW = ((PW + 2) > 17) ? (PW + 2) : 17;

  localparam logic [1:0] PH_FLAGS = 2'd0;
  localparam logic [1:0] PH_XDATA = 2'd1;
  localparam logic [1:0] PH_YDATA = 2'd2;

  logic [SIZE_W-1:0] width_r, height_r;

  logic     s0_valid_r;
  in_item_t s0_item_r;
  logic     s1_go;

  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic [1:0]                phase_r, phase_nxt;
  logic [7:0]                flags_r, flags_nxt;
  logic [7:0]                xbyte_r, xbyte_nxt;
  logic [PW-1:0]             cur_x_r, cur_x_nxt;
  logic [PW-1:0]             cur_y_r, cur_y_nxt;
  logic [2:0]                buttons_r, buttons_nxt;
  logic signed [REL_BITS-1:0] acc_dx_r, acc_dx_nxt;
  logic signed [REL_BITS-1:0] acc_dy_r, acc_dy_nxt;

  logic [COORD_BITS-1:0] hi_x, hi_y;
  logic signed [8:0]     dx, dy;
  logic signed [CLW-1:0] mv_x, mv_y, st_x, st_y;
  logic signed [REL_BITS-1:0] show_dx, show_dy;
  logic [31:0] px_w, py_w;
  logic [31:0] rx_w, ry_w;
  logic done, dropped;

  function automatic logic [COORD_BITS-1:0] max_coord(input logic [SIZE_W-1:0] size);
    logic [31:0] s;
    logic [31:0] lim;
    lim = 32'd1 << COORD_BITS;
    s = {{(32-SIZE_W){1'b0}}, size};
    if (s == 32'd0) s = 32'd1;
    if (s > lim) s = lim;
    s = s - 32'd1;
    return s[COORD_BITS-1:0];
  endfunction

  function automatic logic [PW-1:0] clamp_c(input logic signed [CLW-1:0] v,
                                            input logic [COORD_BITS-1:0] hi);
    logic [CLW-1:0] hi_e;
    logic [CLW-1:0] r;
    hi_e = {{(CLW-COORD_BITS){1'b0}}, hi};
    if (v[CLW-1]) r = '0;
    else if (v > signed'(hi_e)) r = hi_e;
    else r = v;
    return r[PW-1:0];
  endfunction

  function automatic logic signed [REL_BITS-1:0] sat_add(
      input logic signed [REL_BITS-1:0] a, input logic signed [8:0] d);
    logic signed [REL_BITS:0] s;
    s = {a[REL_BITS-1], a} + {{(REL_BITS-8){d[8]}}, d};
    if (s[REL_BITS] != s[REL_BITS-1]) return {s[REL_BITS], {(REL_BITS-1){~s[REL_BITS]}}};
    return s[REL_BITS-1:0];
  endfunction

  // Handshake
  assign s1_go       = s0_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s0_valid_r || s1_go;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  assign hi_x = max_coord(width_r);
  assign hi_y = max_coord(height_r);
  assign dx   = {flags_r[4], xbyte_r};
  assign dy   = {flags_r[5], s0_item_r.data_byte};
  assign mv_x = signed'({{(CLW-PW){1'b0}}, cur_x_r}) + {{(CLW-9){dx[8]}}, dx};
  assign mv_y = signed'({{(CLW-PW){1'b0}}, cur_y_r}) - {{(CLW-9){dy[8]}}, dy};
  assign st_x = {{(CLW-16){s0_item_r.set_x[15]}}, s0_item_r.set_x};
  assign st_y = {{(CLW-16){s0_item_r.set_y[15]}}, s0_item_r.set_y};

  always_comb begin
    phase_nxt   = phase_r;
    flags_nxt   = flags_r;
    xbyte_nxt   = xbyte_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    buttons_nxt = buttons_r;
    acc_dx_nxt  = acc_dx_r;
    acc_dy_nxt  = acc_dy_r;
    done        = 1'b0;
    dropped     = 1'b0;
    case (s0_item_r.action)
      ACT_BYTE: begin
        if (s0_item_r.from_aux) begin
          case (phase_r)
            PH_XDATA: begin
              xbyte_nxt = s0_item_r.data_byte;
              phase_nxt = PH_YDATA;
            end
            PH_YDATA: begin
              phase_nxt   = PH_FLAGS;
              done        = 1'b1;
              buttons_nxt = 3'(flags_r & FLAG_BUTTONS);
              if ((flags_r & FLAG_OVERFLOW) != 8'd0) begin
                dropped = 1'b1;
              end else begin
                acc_dx_nxt = sat_add(acc_dx_r, dx);
                acc_dy_nxt = sat_add(acc_dy_r, dy);
                cur_x_nxt  = clamp_c(mv_x, hi_x);
                cur_y_nxt  = clamp_c(mv_y, hi_y);
              end
            end
            default: begin
              // a first byte without the sync bit is dropped to resync framing
              if ((s0_item_r.data_byte & FLAG_SYNC) != 8'd0) begin
                flags_nxt = s0_item_r.data_byte;
                phase_nxt = PH_XDATA;
              end else begin
                phase_nxt = PH_FLAGS;
              end
            end
          endcase
        end
      end
      ACT_READ: begin
        acc_dx_nxt = '0;
        acc_dy_nxt = '0;
      end
      ACT_SET: begin
        cur_x_nxt   = clamp_c(st_x, hi_x);
        cur_y_nxt   = clamp_c(st_y, hi_y);
        buttons_nxt = s0_item_r.set_buttons;
      end
      default: begin
      end
    endcase
  end

  // Read shows the motion before clearing
  assign show_dx = (s0_item_r.action == ACT_READ) ? acc_dx_r : acc_dx_nxt;
  assign show_dy = (s0_item_r.action == ACT_READ) ? acc_dy_r : acc_dy_nxt;
  assign px_w = 32'(cur_x_nxt);
  assign py_w = 32'(cur_y_nxt);
  assign rx_w = 32'(show_dx);
  assign ry_w = 32'(show_dy);

  always_comb begin
    out_item_nxt.pos_x          = px_w[POS_W-1:0];
    out_item_nxt.pos_y          = py_w[POS_W-1:0];
    out_item_nxt.button_bits    = buttons_nxt;
    out_item_nxt.rel_x          = rx_w[RELO_W-1:0];
    out_item_nxt.rel_y          = ry_w[RELO_W-1:0];
    out_item_nxt.packet_done    = done;
    out_item_nxt.motion_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
      if (cfg_index == CFG_HEIGHT) height_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FLAGS;
      flags_r     <= '0;
      xbyte_r     <= '0;
      cur_x_r     <= PW'(RST_X);
      cur_y_r     <= PW'(RST_Y);
      buttons_r   <= '0;
      acc_dx_r    <= '0;
      acc_dy_r    <= '0;
    end else begin
      if (in_if.ready) s0_valid_r <= in_if.valid;
      if (s1_go) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        flags_r     <= flags_nxt;
        xbyte_r     <= xbyte_nxt;
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        buttons_r   <= buttons_nxt;
        acc_dx_r    <= acc_dx_nxt;
        acc_dy_r    <= acc_dy_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) s0_item_r <= in_if.data;
    if (s1_go) out_item_r <= out_item_nxt;
  end

  // Third mouse byte closes the packet and flags it on the result
  a_packet_close: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s0_item_r.action == ACT_BYTE && s0_item_r.from_aux && phase_r == PH_YDATA
    |=> phase_r == PH_FLAGS && out_valid_r && out_item_r.packet_done)
    else $error("packet not closed on third byte");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s0_item_r.action == ACT_READ |=> acc_dx_r == '0 && acc_dy_r == '0)
    else $error("relative motion not cleared on read");

  a_set_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s0_item_r.action == ACT_SET
    |=> cur_x_r <= PW'($past(hi_x)) && cur_y_r <= PW'($past(hi_y)))
    else $error("set position outside screen");

  a_drop_only_on_packet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !done |=> !out_item_r.motion_dropped)
    else $error("motion dropped without a packet");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for the PS/2 mouse packet tracker: directed, screen-size, saturation and random traffic.
`timescale 1ns / 100ps

module tb;
  import ps2mt_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] PH_FLAGS = 2'd0;
  localparam logic [1:0] PH_XBYTE = 2'd1;
  localparam logic [1:0] PH_YBYTE = 2'd2;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  ps2mt_in_if in_ch ();
  ps2mt_out_if res_ch ();

  ps2_mouse_packet_tracker_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_if(in_ch),
    .out_if(res_ch)
  );

  // Tracker mirror
  logic [1:0] frame_phase;
  logic [7:0] held_flags;
  logic [7:0] held_xbyte;
  logic [2:0] held_btn;
  int cur_x;
  int cur_y;
  int acc_x;
  int acc_y;
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;

  out_item_t awaited_reports[$];
  int mismatches;
  int useful_sent;
  int quiet_cycles;
  int src_idle;
  int snk_idle;

  always #4 clk = ~clk;

  function automatic int clamp_coord(int v, logic [SIZE_W-1:0] size);
    int top;
    if (size == 0) top = 0;
    else if (size > (1 << COORD_BITS_DEF)) top = (1 << COORD_BITS_DEF) - 1;
    else top = int'(size) - 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic int sat_motion(int v);
    int lim;
    lim = (1 << (REL_BITS_DEF - 1)) - 1;
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  function automatic int delta9(logic [7:0] b, logic neg);
    return neg ? int'(b) - 256 : int'(b);
  endfunction

  function automatic out_item_t advance_tracker(in_item_t it);
    out_item_t r;
    int dx;
    int dy;
    r = '0;
    if (it.action == ACT_BYTE && it.from_aux) begin
      if (frame_phase == PH_XBYTE) begin
        held_xbyte = it.data_byte;
        frame_phase = PH_YBYTE;
      end else if (frame_phase == PH_YBYTE) begin
        frame_phase = PH_FLAGS;
        r.packet_done = 1'b1;
        held_btn = held_flags[2:0];
        if ((held_flags & FLAG_OVERFLOW) != 0) begin
          r.motion_dropped = 1'b1;
        end else begin
          dx = delta9(held_xbyte, (held_flags & FLAG_XSIGN) != 0);
          dy = delta9(it.data_byte, (held_flags & FLAG_YSIGN) != 0);
          acc_x = sat_motion(acc_x + dx);
          acc_y = sat_motion(acc_y + dy);
          cur_x = clamp_coord(cur_x + dx, scr_w);
          // screen Y grows downward
          cur_y = clamp_coord(cur_y - dy, scr_h);
        end
      end else if ((it.data_byte & FLAG_SYNC) != 0) begin
        held_flags = it.data_byte;
        frame_phase = PH_XBYTE;
      end else begin
        frame_phase = PH_FLAGS;
      end
    end else if (it.action == ACT_SET) begin
      cur_x = clamp_coord($signed(it.set_x), scr_w);
      cur_y = clamp_coord($signed(it.set_y), scr_h);
      held_btn = it.set_buttons;
    end
    r.rel_x = acc_x[RELO_W-1:0];
    r.rel_y = acc_y[RELO_W-1:0];
    if (it.action == ACT_READ) begin
      acc_x = 0;
      acc_y = 0;
    end
    r.pos_x = cur_x[POS_W-1:0];
    r.pos_y = cur_y[POS_W-1:0];
    r.button_bits = held_btn;
    return r;
  endfunction

  // Entered and left at a falling edge; valid stays high for back-to-back transactions.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    awaited_reports.push_back(advance_tracker(it));
    if (!(it.action == ACT_SPARE || (it.action == ACT_BYTE && !it.from_aux)))
      useful_sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t noise_fields();
    in_item_t it;
    it.action = 2'($urandom);
    it.from_aux = 1'($urandom);
    it.data_byte = 8'($urandom);
    it.set_x = 16'($urandom);
    it.set_y = 16'($urandom);
    it.set_buttons = 3'($urandom);
    return it;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'(int'($urandom_range(8400)) - 100);
  endfunction

  task automatic send_byte(logic aux, logic [7:0] b);
    in_item_t it;
    it = noise_fields();
    it.action = ACT_BYTE;
    it.from_aux = aux;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_read();
    in_item_t it;
    it = noise_fields();
    it.action = ACT_READ;
    send_item(it);
  endtask

  task automatic send_set(logic signed [15:0] x, logic signed [15:0] y, logic [2:0] b);
    in_item_t it;
    it = noise_fields();
    it.action = ACT_SET;
    it.set_x = x;
    it.set_y = y;
    it.set_buttons = b;
    send_item(it);
  endtask

  task automatic send_spare();
    in_item_t it;
    it = noise_fields();
    it.action = ACT_SPARE;
    send_item(it);
  endtask

  // Transactions that must not disturb the framing
  task automatic maybe_noise(int pct);
    if ($urandom_range(99) < pct) begin
      case ($urandom_range(3))
        0: send_read();
        1: send_set(rand_coord(), rand_coord(), 3'($urandom));
        2: send_byte(1'b0, 8'($urandom));
        default: send_spare();
      endcase
    end
  endtask

  task automatic send_packet(logic [7:0] flags, logic [7:0] xb, logic [7:0] yb, int noise_pct);
    send_byte(1'b1, flags);
    maybe_noise(noise_pct);
    send_byte(1'b1, xb);
    maybe_noise(noise_pct);
    send_byte(1'b1, yb);
  endtask

  function automatic logic [7:0] rand_flags();
    logic [1:0] ovf;
    ovf = ($urandom_range(9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    return {ovf, 2'($urandom), 1'b1, 3'($urandom)};
  endfunction

  // Drain all results, then give the pipeline time to go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_screen(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data <= w;
    scr_w = w;
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= h;
    scr_h = h;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_framing();
    send_byte(1'b1, 8'h00);                   // no sync bit: dropped
    send_packet(8'h08, 8'h00, 8'h00, 0);
    send_packet(8'h2F, 8'hFF, 8'h00, 0);      // +255 / -256, all buttons
    send_byte(1'b1, 8'h18);
    send_byte(1'b0, 8'hFF);                   // keyboard byte mid-packet
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'hFF);
    send_packet(8'hC8, 8'hFF, 8'hFF, 0);      // both overflow bits
    send_spare();
    send_byte(1'b1, 8'h4B);
    send_set(-16'sd32768, 16'sd32767, 3'd5);  // set inside a packet
    send_byte(1'b1, 8'h80);
    send_byte(1'b1, 8'h7F);
    send_read();
    send_read();
    send_set(16'sd32767, -16'sd32768, 3'd0);
    send_byte(1'b1, 8'hF7);
    send_set(16'sd0, 16'sd0, 3'd7);
  endtask

  task automatic test_screen_sizes();
    logic [SIZE_W-1:0] sizes[8];
    sizes = '{14'd0, 14'd1, 14'd2, 14'd8191, 14'd8192, 14'd8193, 14'd16383,
              14'($urandom)};
    for (int i = 0; i < 8; i++) begin
      set_screen(sizes[i], sizes[(i + 3) % 8]);
      send_read();                            // size change alone keeps position
      send_packet(rand_flags(), 8'($urandom), 8'($urandom), 0);
      send_set(16'sd32767, 16'sd32767, 3'($urandom));
      send_packet(8'h28, 8'hFF, 8'h00, 0);
      send_set(-16'sd32768, -16'sd32768, 3'($urandom));
      send_packet(8'h18, 8'h00, 8'hFF, 0);
      send_set(rand_coord(), rand_coord(), 3'($urandom));
    end
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 135; i++) send_packet(8'h28, 8'hFF, 8'h00, 0);
    send_read();
    for (int i = 0; i < 135; i++) send_packet(8'h18, 8'h00, 8'hFF, 0);
    send_read();
  endtask

  task automatic test_random_traffic(int target);
    int pick;
    useful_sent = 0;
    while (useful_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_packet(rand_flags(), 8'($urandom), 8'($urandom), 12);
      end else if (pick < 74) begin
        // truncated packet, framing slips until a non-sync byte
        send_byte(1'b1, rand_flags());
        send_byte(1'b1, 8'($urandom));
      end else if (pick < 82) begin
        send_read();
      end else if (pick < 88) begin
        send_set(rand_coord(), rand_coord(), 3'($urandom));
      end else if (pick < 94) begin
        send_byte(1'b1, 8'($urandom));
      end else if (pick < 97) begin
        send_byte(1'b0, 8'($urandom));
      end else begin
        send_spare();
      end
    end
  endtask

  always @(negedge clk) res_ch.ready <= ($urandom_range(99) >= snk_idle);

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : res_check
    out_item_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("pos_x", want.pos_x, res_ch.data.pos_x);
        check_field("pos_y", want.pos_y, res_ch.data.pos_y);
        check_field("button_bits", want.button_bits, res_ch.data.button_bits);
        check_field("rel_x", $signed(want.rel_x), $signed(res_ch.data.rel_x));
        check_field("rel_y", $signed(want.rel_y), $signed(res_ch.data.rel_y));
        check_field("packet_done", want.packet_done, res_ch.data.packet_done);
        check_field("motion_dropped", want.motion_dropped, res_ch.data.motion_dropped);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    res_ch.ready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    useful_sent = 0;
    src_idle = 35;
    snk_idle = 66;
    frame_phase = PH_FLAGS;
    held_flags = '0;
    held_xbyte = '0;
    held_btn = '0;
    cur_x = RST_X;
    cur_y = RST_Y;
    acc_x = 0;
    acc_y = 0;
    scr_w = RST_WIDTH;
    scr_h = RST_HEIGHT;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_framing();
    test_screen_sizes();

    set_screen(14'd320, 14'd200);
    test_random_traffic(RANDOM_PER_PHASE);

    src_idle = 66;
    snk_idle = 35;
    set_screen(14'($urandom_range(1, 16383)), 14'($urandom_range(1, 16383)));
    test_random_traffic(RANDOM_PER_PHASE);
    set_screen(14'd1024, 14'd768);
    test_saturation();

    src_idle = 0;
    snk_idle = 0;
    set_screen(14'd8192, 14'd8192);
    test_random_traffic(RANDOM_PER_PHASE);

    settle();
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
